// ===== hdl/trq_pkg.sv =====
// ----------------------------------------------------------------------------
// trq_pkg
// Types and codes shared by the thread ready queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_FIND = 2'd2,
    OP_REM  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_EMIT
  } state_t;

  // packed field widths of the result item
  localparam int RID_W = 8;
  localparam int OCC_W = 5;

endpackage

`default_nettype wire

// ===== hdl/trq_mem.sv =====
// ----------------------------------------------------------------------------
// trq_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/thread_ready_queue.sv =====
// ----------------------------------------------------------------------------
// thread_ready_queue
// Ordered ready list of thread ids with enqueue, dequeue, find and remove.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one request item: in_tuser holds the opcode
//   (enqueue, dequeue, find, remove) and in_tdata the thread id. Every
//   request gives exactly one item on the out_ channel carrying the id,
//   a hit flag, a status code and the occupancy after the request.
//   Requests are handled one at a time; in_tready is high only while the
//   sequencer is idle. All entry accesses go through the one entry memory
//   and a single slot adder, one access per cycle:
//     enqueue          writes the tail slot on accept, then emits the result
//     dequeue          reads the head, takes the data, then emits (an empty queue emits directly)
//     find             reads and compares the entries in order from the head
//     remove           as find, plus a read and a write per entry behind the match
//   The result sits in an output register; the next request may be taken
//   while it waits, and the sequencer holds its finished result if the
//   receiver stalls. Reset empties the queue at once (head and count
//   cleared); entry contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module thread_ready_queue
  import trq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] thread_id
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata   // [7:0] result_id, [8] hit, [10:9] status,
                                       // [15:11] occupancy
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [7:0] ID_MASK8 = 8'((64'd1 << ID_BITS) - 64'd1);

  state_t             state_r, state_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  opcode_t            op_r, op_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [RID_W-1:0]   rid_r, rid_nxt;
  status_t            st_r, st_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [15:0]        out_data_r, out_data_nxt;

  // shared slot unit: (head + offset) mod depth
  logic [CW-1:0] off;
  logic [CW:0]   sum;
  logic [IW-1:0] slot;

  logic               wr_en, rd_en;
  logic [IW-1:0]      wr_addr, rd_addr;
  logic [ID_BITS-1:0] wr_data, rd_data;

  logic [ID_BITS-1:0] in_id;
  logic [CW-1:0]      kp1, kp2, cnt_dec;
  opcode_t            in_op;
  logic               in_acc;

  assign in_id   = ID_BITS'(in_tdata & ID_MASK8);
  assign in_op   = opcode_t'(in_tuser);
  assign in_acc  = in_tvalid && in_tready;
  assign kp1     = k_r + CW'(1);
  assign kp2     = k_r + CW'(2);
  assign cnt_dec = cnt_r - CW'(1);

  assign sum  = (CW+1)'(head_r) + (CW+1)'(off);
  assign slot = (sum >= (CW+1)'(QUEUE_DEPTH)) ? IW'(sum - (CW+1)'(QUEUE_DEPTH)) : IW'(sum);

  trq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    rid_r      <= rid_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    rid_nxt      = rid_r;
    st_nxt       = st_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    in_tready    = 1'b0;
    off          = k_r;
    wr_en        = 1'b0;
    wr_addr      = slot;
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = slot;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        off       = '0;
        if (in_acc) begin
          op_nxt  = in_op;
          id_nxt  = in_id;
          rid_nxt = '0;
          st_nxt  = ST_OK;
          k_nxt   = '0;
          unique case (in_op)
            OP_ENQ: begin
              off       = cnt_r;
              state_nxt = S_EMIT;
              if (cnt_r == CW'(QUEUE_DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_data = in_id;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_DEQ: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_EMIT;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DEQ_WAIT;
              end
            end
            OP_FIND, OP_REM: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_NOTFOUND;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_DEQ_WAIT: begin
        off       = CW'(1);
        rid_nxt   = RID_W'(rd_data);
        cnt_nxt   = cnt_dec;
        head_nxt  = (cnt_dec == '0) ? '0 : slot;
        state_nxt = S_EMIT;
      end

      S_SRCH_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (rd_data == id_r) begin
          rid_nxt = RID_W'(id_r);
          if (op_r == OP_REM && kp1 < cnt_r) begin
            state_nxt = S_MOVE_RD;
          end else begin
            if (op_r == OP_REM) begin
              cnt_nxt = cnt_dec;
              if (cnt_dec == '0) begin
                head_nxt = '0;
              end
            end
            state_nxt = S_EMIT;
          end
        end else begin
          k_nxt = kp1;
          if (kp1 == cnt_r) begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end

      // close the gap: entry k+1 moves down to k
      S_MOVE_RD: begin
        off       = kp1;
        rd_en     = 1'b1;
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        wr_en = 1'b1;
        k_nxt = kp1;
        if (kp2 < cnt_r) begin
          state_nxt = S_MOVE_RD;
        end else begin
          cnt_nxt   = cnt_dec;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {OCC_W'(cnt_r), st_r, (st_r == ST_OK), rid_r};
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == '0))
    else $error("head not reset on empty queue");

  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8] == (out_tdata[10:9] == ST_OK)))
    else $error("hit flag disagrees with status");

  a_emit_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_vld_r || out_tready)) |=> (out_vld_r && state_r == S_IDLE))
    else $error("finished result not loaded into output register");

endmodule

`default_nettype wire

// ===== sim/thread_ready_queue_tb.sv =====
// ----------------------------------------------------------------------------
// thread_ready_queue_tb
// Self-checking bench for the thread ready queue. A short directed sequence
// walks the empty, full, duplicate and miss cases, then phases of random
// requests fill, drain and search the queue. Both stream sides idle and stall
// at random. Every reply is checked against a behavioral copy of the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thread_ready_queue_tb;
  import trq_pkg::*;

  localparam int  DEPTH        = 16;
  localparam int  RANDOM_ITEMS = 1650;
  localparam int  DRAIN_CYCLES = 80;
  localparam real RUN_LIMIT_NS = 10_000_000.0;

  typedef struct packed {
    logic [4:0] occupancy;
    status_t    status;
    logic       hit;
    logic [7:0] result_id;
  } reply_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_SEARCH, MIX_NOISE} mix_t;

  // ordered copy of the ready list plus the replies it implies
  class ready_list_checker;
    logic [7:0] ready_list[$];
    reply_t     awaited_replies[$];
    int         mismatches;
    int         replies_checked;
    int         status_seen[4];

    function void note_request(opcode_t op, logic [7:0] id);
      reply_t r;
      int     k;
      int     found;
      r.result_id = 8'd0;
      r.status    = ST_OK;
      found       = -1;
      case (op)
        OP_ENQ: begin
          if (ready_list.size() >= DEPTH) r.status = ST_FULL;
          else ready_list.push_back(id);
        end
        OP_DEQ: begin
          if (ready_list.size() == 0) r.status = ST_EMPTY;
          else r.result_id = ready_list.pop_front();
        end
        default: begin
          for (k = 0; k < ready_list.size(); k++) begin
            if (found < 0 && ready_list[k] == id) found = k;
          end
          if (found < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.result_id = id;
            // oldest match only, the rest keep their order
            if (op == OP_REM) ready_list.delete(found);
          end
        end
      endcase
      r.hit       = (r.status == ST_OK);
      r.occupancy = 5'(ready_list.size());
      awaited_replies.push_back(r);
    endfunction

    function void check_reply(logic [15:0] word);
      reply_t got;
      reply_t want;
      got = reply_t'(word);
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply item %h with nothing outstanding", word);
        return;
      end
      want = awaited_replies.pop_front();
      replies_checked++;
      status_seen[want.status]++;
      if (got.result_id !== want.result_id || got.hit !== want.hit ||
          got.status !== want.status || got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply %0d: id %h/%h hit %b/%b status %0d/%0d occ %0d/%0d (exp/got)",
                   replies_checked, want.result_id, got.result_id, want.hit, got.hit,
                   want.status, got.status, want.occupancy, got.occupancy);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] thread_id
  logic [1:0]  in_tuser   = OP_ENQ; // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [7:0] result_id, [8] hit, [10:9] status,
                                    // [15:11] occupancy

  ready_list_checker chk = new();
  bit                quiet;
  int                items_sent;
  int                ready_hold;
  int                ready_roll;

  thread_ready_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  // receiver: runs of ready and stall, with occasional long stalls
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(0, 4);
      end else if (ready_roll < 93) begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) chk.check_reply(out_tdata);
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ids: often a live entry, often a small pool so duplicates pile up
  function automatic logic [7:0] pick_id(int live_pct);
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    n    = chk.ready_list.size();
    if (n > 0 && roll < live_pct) return chk.ready_list[$urandom_range(0, n - 1)];
    if (roll < live_pct + 25) return 8'($urandom_range(0, 5) * 51);
    return 8'($urandom);
  endfunction

  function automatic opcode_t pick_op(mix_t mix);
    int roll;
    int enq_w;
    int deq_w;
    int find_w;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   begin enq_w = 65; deq_w = 10; find_w = 12; end
      MIX_DRAIN:  begin enq_w = 15; deq_w = 55; find_w = 15; end
      MIX_SEARCH: begin enq_w = 30; deq_w = 10; find_w = 30; end
      default:    begin enq_w = 25; deq_w = 25; find_w = 25; end
    endcase
    if (roll < enq_w) return OP_ENQ;
    if (roll < enq_w + deq_w) return OP_DEQ;
    if (roll < enq_w + deq_w + find_w) return OP_FIND;
    return OP_REM;
  endfunction

  task automatic send_request(opcode_t op, logic [7:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= id;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chk.note_request(op, id);
    items_sent++;
  endtask

  initial begin
    int   i;
    int   run_len;
    mix_t mix;
    opcode_t op;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue: dequeue, find and remove all miss
    send_request(OP_DEQ, 8'h00);
    send_request(OP_FIND, 8'h00);
    send_request(OP_REM, 8'hff);
    // fill to the top with a duplicate of zero and 255 at the tail
    for (i = 0; i < DEPTH; i++) begin
      if (i == 0 || i == 5) send_request(OP_ENQ, 8'h00);
      else if (i == DEPTH - 1) send_request(OP_ENQ, 8'hff);
      else send_request(OP_ENQ, 8'(i * 17));
    end
    send_request(OP_ENQ, 8'h5a);      // rejected, full
    send_request(OP_FIND, 8'h00);     // duplicate, oldest answers
    send_request(OP_FIND, 8'h5a);     // miss on a full queue
    send_request(OP_REM, 8'h00);      // oldest copy at the head
    send_request(OP_REM, 8'hff);      // tail entry
    send_request(OP_REM, 8'h00);      // second copy, now mid list
    send_request(OP_DEQ, 8'hff);

    i = 0;
    while (i < RANDOM_ITEMS) begin
      run_len = $urandom_range(20, 80);
      mix     = mix_t'($urandom_range(0, 3));
      quiet   = ($urandom_range(0, 4) == 0);
      repeat (run_len) begin
        op = pick_op(mix);
        if (mix == MIX_NOISE) send_request(op, 8'($urandom));
        else send_request(op, pick_id(op == OP_ENQ ? 20 : 60));
        i++;
      end
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (chk.awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d requests, %0d replies checked", items_sent, chk.replies_checked);
    $display("status mix: ok %0d, empty %0d, full %0d, not found %0d",
             chk.status_seen[ST_OK], chk.status_seen[ST_EMPTY],
             chk.status_seen[ST_FULL], chk.status_seen[ST_NOTFOUND]);
    if (chk.mismatches == 0 && chk.awaited_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", chk.mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
